>>> src/stt_pkg.sv
// Package for the software timer slot table: transaction types, command and
// result codes, sequencer states and default sizes.
// No dependencies.
package stt_pkg;

    // Default number of timer slots.
    localparam int SLOTS_DEF = 16;

    // Width of a period and of a countdown value.
    localparam int PERIOD_W = 32;

    // Command codes.
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_TIMEOUT  = 2'd1;
    localparam logic [1:0] CMD_INTERVAL = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_ALLOC   = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_EXPIRED = 3'd2;
    localparam logic [2:0] KIND_TICKED  = 3'd3;
    localparam logic [2:0] KIND_CLEARED = 3'd4;

    // Input transaction.
    typedef struct packed {
        logic [1:0]          cmd;
        logic [PERIOD_W-1:0] period;
        logic [3:0]          slot_id;
    } stt_in_t;

    // Result transaction.
    typedef struct packed {
        logic [2:0]          kind;
        logic [3:0]          slot;
        logic [PERIOD_W-1:0] expired_period;
        logic                last;
    } stt_out_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_SCAN,
        ST_TICK_EXEC,
        ST_TICK_DONE,
        ST_SET_SCAN,
        ST_CLEAR
    } stt_state_t;

endpackage

>>> src/software_timer_slot_table_unit.sv
// Top level of the software timer slot table: sequencer, slot flags and output register.
// Depends on stt_pkg and stt_ram.
//
//  Channel | Ports                      | Carries
//  --------+----------------------------+----------------------------------------
//  s_      | s_valid, s_ready, s_data   | command: tick, timeout, interval, clear
//  m_      | m_valid, m_ready, m_data   | results: alloc, full, expired, ticked, cleared
//
// A tick walks the slots one at a time through a single decrement and zero
// compare unit: ST_IDLE accepts it, ST_TICK_SCAN skips a free slot, an active
// slot goes on through ST_TICK_EXEC, and ST_TICK_DONE reports after the end
// of the table.
// A set command scans for the lowest free slot; clear frees the named slot.
// The slot memory port (one read and one write per cycle at one address) sets the tick length.
// Reset clears the sequencer, the slot flags and the output valid; countdown memory contents are left as they are.
// A stalled result holds the sequencer, when it has a new result to give, until the output register frees up.
module software_timer_slot_table_unit #(
    parameter int SLOTS = stt_pkg::SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  stt_pkg::stt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output stt_pkg::stt_out_t m_data
);
    import stt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int RAM_W  = 2 * PERIOD_W;

    stt_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    stt_in_t            cmd_reg, cmd_next;
    logic [SLOTS-1:0]   active_reg, active_next;
    logic [SLOTS-1:0]   repeats_reg, repeats_next;
    logic               m_valid_reg, m_valid_next;
    stt_out_t           m_data_reg, m_data_next;

    logic [SLOT_W-1:0]  slot_addr;
    logic [SLOT_W-1:0]  clear_idx;
    logic [6:0]         clear_ext;
    logic               ram_we;
    logic [RAM_W-1:0]   ram_wdata;
    logic [RAM_W-1:0]   ram_rdata;
    logic [PERIOD_W-1:0] rem_dec;
    logic [PERIOD_W-1:0] reload_val;
    logic               rem_zero;
    logic               out_free;
    logic               at_end;

    // Slot memory: reload period in the upper half, remaining count in the lower.
    stt_ram #(
        .WIDTH(RAM_W),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (slot_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // Shared decrement and zero-compare unit.
    assign slot_addr  = idx_reg[SLOT_W-1:0];
    assign reload_val = ram_rdata[RAM_W-1:PERIOD_W];
    assign rem_dec    = ram_rdata[PERIOD_W-1:0] - PERIOD_W'(1);
    assign rem_zero   = (rem_dec == '0);
    assign out_free   = !m_valid_reg || m_ready;
    assign at_end     = (idx_reg == CNT_W'(SLOTS));
    assign clear_idx  = SLOT_W'(cmd_reg.slot_id);
    assign clear_ext  = 7'(cmd_reg.slot_id);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            active_reg  <= '0;
            repeats_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            active_reg  <= active_next;
            repeats_reg <= repeats_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_data_reg <= m_data_next;
    end

    // Sequencer: next state, slot flag updates, memory writes and results.
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd_next     = cmd_reg;
        active_next  = active_reg;
        repeats_next = repeats_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_we       = 1'b0;
        ram_wdata    = {reload_val, rem_dec};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_data;
                    idx_next = '0;
                    case (s_data.cmd)
                        CMD_TICK:     state_next = ST_TICK_SCAN;
                        CMD_TIMEOUT,
                        CMD_INTERVAL: state_next = ST_SET_SCAN;
                        CMD_CLEAR:    state_next = ST_CLEAR;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end

            // Skip free slots; an active slot's data is read at this edge.
            ST_TICK_SCAN: begin
                if (at_end) begin
                    state_next = ST_TICK_DONE;
                end else if (active_reg[slot_addr]) begin
                    state_next = ST_TICK_EXEC;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            // Decrement one slot; an expiring slot waits for the output register.
            ST_TICK_EXEC: begin
                if (!rem_zero || out_free) begin
                    ram_we   = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                    state_next = ST_TICK_SCAN;
                    if (rem_zero) begin
                        if (repeats_reg[slot_addr]) begin
                            ram_wdata = {reload_val, reload_val};
                        end else begin
                            active_next[slot_addr]  = 1'b0;
                            repeats_next[slot_addr] = 1'b0;
                        end
                        m_valid_next = 1'b1;
                        m_data_next  = '{kind: KIND_EXPIRED, slot: 4'(slot_addr),
                                         expired_period: reload_val, last: 1'b0};
                    end
                end
            end

            ST_TICK_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{kind: KIND_TICKED, slot: '0,
                                     expired_period: '0, last: 1'b1};
                    state_next   = ST_IDLE;
                end
            end

            // Lowest free slot search, one slot per cycle.
            ST_SET_SCAN: begin
                if (at_end) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{kind: KIND_FULL, slot: '0,
                                         expired_period: '0, last: 1'b1};
                        state_next   = ST_IDLE;
                    end
                end else if (!active_reg[slot_addr]) begin
                    if (out_free) begin
                        ram_we    = 1'b1;
                        ram_wdata = {cmd_reg.period, cmd_reg.period};
                        active_next[slot_addr]  = 1'b1;
                        repeats_next[slot_addr] = (cmd_reg.cmd == CMD_INTERVAL);
                        m_valid_next = 1'b1;
                        m_data_next  = '{kind: KIND_ALLOC, slot: 4'(slot_addr),
                                         expired_period: '0, last: 1'b1};
                        state_next   = ST_IDLE;
                    end
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            // Free the named slot; an id beyond the table changes nothing.
            ST_CLEAR: begin
                if (out_free) begin
                    if (clear_ext < 7'(SLOTS)) begin
                        active_next[clear_idx]  = 1'b0;
                        repeats_next[clear_idx] = 1'b0;
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = '{kind: KIND_CLEARED, slot: cmd_reg.slot_id,
                                     expired_period: '0, last: 1'b1};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/stt_ram.sv
// Generic single-port RAM with a registered read port (read before write).
// No dependencies.
module stt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle at the same address.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
